// ===== rtl/core/cfd_pkg.sv =====
// Package for the control frame deframer.
// Holds the frame layout constants and the types shared by the check logic and the top level.
// Depends on nothing.
package cfd_pkg;

  localparam int unsigned FrameBytes = 10;
  localparam int unsigned WinBytes   = FrameBytes - 1;
  localparam int unsigned FillW      = 4;

  localparam logic [7:0] HeadByte = 8'h42;
  localparam logic [7:0] AddrByte = 8'h01;
  localparam logic [7:0] LenByte  = 8'h0A;

  localparam logic [FillW-1:0] FillFull = FillW'(WinBytes);

  typedef logic [FrameBytes-1:0][7:0] frame_t;
  typedef logic [WinBytes-1:0][7:0]   window_t;

  typedef struct packed {
    logic        match;
    logic [31:0] speed_bits;
    logic [15:0] servo_pulse;
  } check_t;

endpackage

// ===== rtl/core/cfd_check.sv =====
// Frame check for the control frame deframer.
// Tests header, checksum and speed exponent of one full frame and extracts its fields.
// Depends on cfd_pkg.
module cfd_check (
  input  cfd_pkg::frame_t frame_i,
  output cfd_pkg::check_t check_o
);
  import cfd_pkg::*;

  logic [7:0] sum_lo;
  logic [7:0] sum_hi;
  logic [7:0] sum;
  logic       head_ok;
  logic       sum_ok;
  logic       finite_ok;

  // The checksum covers bytes 0 to 8, split in two partial sums.
  assign sum_lo = frame_i[0] + frame_i[1] + frame_i[2] + frame_i[3] + frame_i[4];
  assign sum_hi = frame_i[5] + frame_i[6] + frame_i[7] + frame_i[8];
  assign sum    = sum_lo + sum_hi;

  assign head_ok   = (frame_i[0] == HeadByte) && (frame_i[1] == AddrByte) &&
                     (frame_i[2] == LenByte);
  assign sum_ok    = (sum == frame_i[9]);
  assign finite_ok = !((frame_i[6][6:0] == 7'h7F) && frame_i[5][7]);

  assign check_o.match       = head_ok && sum_ok && finite_ok;
  assign check_o.speed_bits  = {frame_i[6], frame_i[5], frame_i[4], frame_i[3]};
  assign check_o.servo_pulse = {frame_i[8], frame_i[7]};

endmodule

// ===== rtl/core/control_frame_deframer_core.sv =====
// Top level of the control frame deframer.
// Registers each received byte, checks the frame window and holds a matched result.
// Depends on cfd_pkg and cfd_check.

// The block takes one received byte per beat and accepts a new byte in every cycle
// while the result side keeps up. A byte passes an input register, then the window
// check, and the fields of a matched frame are registered into the result register
// that drives the output. The window keeps the last nine bytes; when a tenth arrives
// the frame is checked, and on a match the speed and servo fields are emitted and the
// window empties, otherwise the oldest byte is dropped. Throughput is set by the result
// register: while a result waits, at most one more byte is taken into the input register.
module control_frame_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] speed_bits_o,
  output logic [15:0] servo_pulse_o
);
  import cfd_pkg::*;

  logic                s1_valid_q;
  logic [7:0]          s1_byte_q;
  logic                advance;
  logic                full;
  logic [FillW-1:0]    fill_q;
  logic [FillW-1:0]    fill_d;
  window_t             win_q;
  window_t             win_d;
  frame_t              frame;
  check_t              chk;
  logic                out_valid_q;
  logic                out_valid_d;
  logic [31:0]         speed_q;
  logic [15:0]         servo_q;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign full       = (fill_q == FillFull);

  always_comb begin
    frame = '0;
    for (int i = 0; i < int'(WinBytes); i++) begin
      frame[i] = win_q[i];
    end
    frame[FrameBytes-1] = s1_byte_q;
  end

  cfd_check u_check (
    .frame_i (frame),
    .check_o (chk)
  );

  always_comb begin
    win_d       = win_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (s1_valid_q && advance) begin
      if (!full) begin
        win_d[fill_q] = s1_byte_q;
        fill_d        = fill_q + FillW'(1);
      end else if (chk.match) begin
        fill_d      = '0;
        out_valid_d = 1'b1;
      end else begin
        for (int i = 0; i < int'(WinBytes) - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[WinBytes-1] = s1_byte_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= rx_byte_i;
    end
    win_q <= win_d;
    if (s1_valid_q && advance && full && chk.match) begin
      speed_q <= chk.speed_bits;
      servo_q <= chk.servo_pulse;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign speed_bits_o  = speed_q;
  assign servo_pulse_o = servo_q;

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull)
    else $error("Window fill count out of range.");

  a_match_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && advance && full && chk.match) |=> (fill_q == '0) && out_valid_q)
    else $error("Matched frame did not empty the window and post a result.");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && full))
    else $error("Result appeared without a full window check.");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> s1_valid_q && $stable(s1_byte_q) && $stable(fill_q))
    else $error("Stalled input beat was lost or changed.");

endmodule

// ===== bench/control_frame_deframer_core_tb.sv =====
// Testbench for control_frame_deframer_core: streams directed and random bytes and frames,
// deframes them in a local model and checks every emitted speed and servo beat in order.
// Depends on cfd_pkg and the control_frame_deframer_core RTL.
`timescale 1ns / 100ps

module control_frame_deframer_core_tb;
  import cfd_pkg::*;

  localparam int LimitCycles = 200000;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic [31:0] speed;
    logic [15:0] servo;
  } servo_cmd_t;

  typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_HEAD} flaw_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] speed_bits_o;
  logic [15:0] servo_pulse_o;

  logic [7:0]  rx_window [FrameBytes];
  int          rx_fill = 0;
  servo_cmd_t  decoded_cmds [$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatches = 0;
  int          cycles = 0;

  control_frame_deframer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .speed_bits_o  (speed_bits_o),
    .servo_pulse_o (servo_pulse_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("control_frame_deframer_core_tb failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] sum;
    int         i;
    if (rx_fill >= FrameBytes) rx_fill = FrameBytes - 1;
    rx_window[rx_fill] = b;
    rx_fill++;
    if (rx_fill == FrameBytes) begin
      sum = 8'h00;
      for (i = 0; i < FrameBytes - 1; i++) sum = sum + rx_window[i];
      if (rx_window[0] == HeadByte && rx_window[1] == AddrByte &&
          rx_window[2] == LenByte && sum == rx_window[9] &&
          !(rx_window[6][6:0] == 7'h7F && rx_window[5][7])) begin
        decoded_cmds.insert(decoded_cmds.size(),
                            {rx_window[6], rx_window[5], rx_window[4], rx_window[3],
                             rx_window[8], rx_window[7]});
        rx_fill = 0;
      end else begin
        for (i = 0; i < FrameBytes - 1; i++) rx_window[i] = rx_window[i + 1];
        rx_fill = FrameBytes - 1;
      end
    end
  endtask

  always @(posedge clk_i) begin
    servo_cmd_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (decoded_cmds.size() == 0) begin
          report_mismatch("result beat with nothing expected", speed_bits_o, 32'h0);
        end else begin
          want = decoded_cmds.pop_front();
          if (speed_bits_o !== want.speed) begin
            report_mismatch("speed_bits", speed_bits_o, want.speed);
          end
          if (servo_pulse_o !== want.servo) begin
            report_mismatch("servo_pulse", {16'h0, servo_pulse_o}, {16'h0, want.servo});
          end
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    deframe_byte(b);
  endtask

  task automatic send_frame(input logic [31:0] speed, input logic [15:0] servo,
                            input flaw_e flaw, input int nbytes);
    logic [7:0] fb [FrameBytes];
    logic [7:0] sum;
    int         i;
    int         idx;
    fb[0] = HeadByte;
    fb[1] = AddrByte;
    fb[2] = LenByte;
    {fb[6], fb[5], fb[4], fb[3]} = speed;
    {fb[8], fb[7]} = servo;
    if (flaw == FLAW_HEAD) begin
      idx = $urandom_range(2);
      fb[idx] = fb[idx] ^ 8'($urandom_range(1, 255));
    end
    sum = 8'h00;
    for (i = 0; i < FrameBytes - 1; i++) sum = sum + fb[i];
    fb[9] = (flaw == FLAW_SUM) ? sum + 8'($urandom_range(1, 255)) : sum;
    for (i = 0; i < nbytes; i++) send_byte(fb[i]);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (decoded_cmds.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic test_field_extremes();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_frame(32'hFF7F_FFFF, 16'hFFFF, FLAW_NONE, FrameBytes);
    send_frame(32'h0000_0000, 16'h0000, FLAW_NONE, FrameBytes);
    wait_drained();
  endtask

  task automatic test_non_finite_speed();
    send_frame(32'h7F80_0000, 16'h05DC, FLAW_NONE, FrameBytes);
    send_byte(8'hFF);
    send_byte(8'h00);
    wait_drained();
  endtask

  task automatic run_traffic(input int n, input int send_pct, input int stall_pct);
    logic [31:0] speed;
    int          sent;
    int          kind;
    int          k;
    int          i;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n) begin
      kind  = $urandom_range(99);
      speed = $urandom;
      if (speed[30:23] == 8'hFF) speed[30] = 1'b0;
      if (kind < 60) begin
        send_frame(speed, 16'($urandom), FLAW_NONE, FrameBytes);
        sent += FrameBytes;
      end else if (kind < 66) begin
        speed[30:23] = 8'hFF;
        send_frame(speed, 16'($urandom), FLAW_NONE, FrameBytes);
        sent += FrameBytes;
      end else if (kind < 72) begin
        send_frame(speed, 16'($urandom), FLAW_SUM, FrameBytes);
        sent += FrameBytes;
      end else if (kind < 78) begin
        send_frame(speed, 16'($urandom), FLAW_HEAD, FrameBytes);
        sent += FrameBytes;
      end else if (kind < 86) begin
        k = $urandom_range(1, FrameBytes - 1);
        send_frame(speed, 16'($urandom), FLAW_NONE, k);
        sent += k;
      end else begin
        k = $urandom_range(1, 6);
        for (i = 0; i < k; i++) begin
          send_byte(($urandom_range(3) == 0) ? HeadByte : 8'($urandom));
        end
        sent += k;
      end
      if ($urandom_range(49) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_non_finite_speed();
    run_traffic(270, 0, 0);
    run_traffic(270, 81, 0);
    run_traffic(270, 0, 81);
    run_traffic(270, 34, 34);
    wait_drained();
    if (mismatches == 0) begin
      $display("control_frame_deframer_core_tb passed");
    end else begin
      $display("control_frame_deframer_core_tb failed");
    end
    $finish;
  end

endmodule
